/* rtl/wrs_pkg.sv */
// Package with the shared constants and control types of the weighted random selector.
package wrs_pkg;

  // Table geometry and field widths.
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxBits    = 10;
  localparam int unsigned CountBits  = 11;
  localparam int unsigned WeightBits = 32;
  localparam int unsigned RandBits   = 31;
  localparam int unsigned ProdBits   = WeightBits + RandBits;

  // Request codes.
  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqSample = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRdTot = 5'b00010,
    StMul   = 5'b00100,
    StSrch  = 5'b01000,
    StChk   = 5'b10000
  } wrs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_entry;   // write a load beat into the table
    logic cap;        // capture a sample beat
    logic mul;        // form the key from the total
    logic step;       // one binary search step
    logic chk_rd;     // read the lower bound entry
    logic chk_take;   // register the selected index
  } wrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;       // search interval still wider than one
  } wrs_sts_t;

endpackage

/* rtl/wrs_ctrl.sv */
// Controller state machine of the weighted random selector.
module wrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wrs_pkg::wrs_sts_t sts_i,
  output wrs_pkg::wrs_cmd_t cmd_o
);
  import wrs_pkg::*;

  wrs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire && req_type_i == ReqLoad) begin
          cmd_o.wr_entry = 1'b1;
        end else if (in_fire && req_type_i == ReqSample) begin
          cmd_o.cap = 1'b1;
          state_d   = StRdTot;
        end
      end
      StRdTot: begin
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.more ? StSrch : StChk;
      end
      StSrch: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.more ? StSrch : StChk;
      end
      StChk: begin
        cmd_o.chk_rd = 1'b1;
        if (out_free) begin
          cmd_o.chk_take = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output valid: set when a result is registered, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.chk_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/wrs_dp.sv */
// Datapath of the weighted random selector: weight table, key scaling and search bounds.
module wrs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wrs_pkg::CountBits-1:0]       cfg_wdata_i,
  input  logic [wrs_pkg::IdxBits-1:0]         entry_index_i,
  input  logic [wrs_pkg::WeightBits-1:0]      cumul_weight_i,
  input  logic [wrs_pkg::RandBits-1:0]        random_value_i,
  output logic [wrs_pkg::IdxBits-1:0]         selected_index_o,
  input  wrs_pkg::wrs_cmd_t                   cmd_i,
  output wrs_pkg::wrs_sts_t                   sts_o
);
  import wrs_pkg::*;

  logic [WeightBits-1:0] table_mem [TableDepth];
  logic [WeightBits-1:0] rdata_q;
  logic [IdxBits-1:0]    raddr, mid_q;
  logic [CountBits-1:0]  count_q;
  logic [RandBits-1:0]   rand_q;
  logic [WeightBits-1:0] key_q, key_d;
  logic [IdxBits-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [IdxBits-1:0]    hi_start;
  logic [IdxBits-1:0]    span;
  logic [IdxBits:0]      mid_sum;
  logic [ProdBits-1:0]   prod;
  logic [IdxBits-1:0]    sel_q;
  logic                  ge;

  // Entry count register, reset to one entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountBits'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Last entry in use: count clamped to one..depth, minus one.
  always_comb begin
    if (count_q == '0) begin
      hi_start = '0;
    end else if (count_q > CountBits'(TableDepth)) begin
      hi_start = IdxBits'(TableDepth - 1);
    end else begin
      hi_start = IdxBits'(count_q - CountBits'(1));
    end
  end

  // Key scaling: (random * total) >> 31, total is the entry read at the top bound.
  assign prod = ProdBits'(rand_q) * ProdBits'(rdata_q);
  assign ge   = (rdata_q >= key_q);

  // Bound update for the current command.
  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    key_d = key_q;
    if (cmd_i.cap) begin
      hi_d = hi_start;
      lo_d = '0;
    end
    if (cmd_i.mul) begin
      key_d = prod[ProdBits-1:RandBits];
      lo_d  = '0;
    end
    if (cmd_i.step) begin
      if (ge) begin
        hi_d = mid_q;
      end else begin
        lo_d = mid_q;
      end
    end
  end

  // Interval width and midpoint of the updated bounds.
  assign span       = hi_d - lo_d;
  assign mid_sum    = {1'b0, hi_d} + {1'b0, lo_d};
  assign sts_o.more = (span > IdxBits'(1));

  // Read address: midpoint while searching, lower bound at the end, else the top bound.
  always_comb begin
    if (cmd_i.mul || cmd_i.step) begin
      raddr = sts_o.more ? mid_sum[IdxBits:1] : lo_d;
    end else if (cmd_i.chk_rd) begin
      raddr = lo_q;
    end else begin
      raddr = hi_q;
    end
  end

  // Weight table with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      table_mem[entry_index_i] <= cumul_weight_i;
    end
    rdata_q <= table_mem[raddr];
  end

  // Search registers and result.
  always_ff @(posedge clk_i) begin
    mid_q <= raddr;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    key_q <= key_d;
    if (cmd_i.cap) begin
      rand_q <= random_value_i;
    end
    if (cmd_i.chk_take) begin
      sel_q <= ge ? lo_q : hi_q;
    end
  end

  assign selected_index_o = sel_q;

endmodule

/* rtl/weighted_random_select.sv */
// Top level of the weighted random selector.
//
// Input channel: in_valid_i/in_ready_o carries one beat with req_type_i,
// entry_index_i, cumul_weight_i and random_value_i. A load beat writes one
// cumulative weight into the 1024-entry table in the accept cycle and gives
// no result; the next beat may follow in the next cycle.
// A sample beat scales random_value_i by the last entry in use to a key and
// binary-searches the table for the first entry reaching it. Its index leaves
// on out_valid_o/out_ready_i as selected_index_o.
// For a full table a sample does one read of the total, the 31x32 multiply,
// up to ten search steps (one table read each) and one check of the lower
// bound. Smaller tables need fewer steps. The single table read port sets
// the length of a sample; one sample is in flight, so the next beat is
// accepted in the same cycle as the result appears. The result sits in an
// output register: when the receiver stalls it holds, and a new beat is
// still accepted, but the next sample waits in its final check until the
// held result is taken. The user must write the entry count through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not
// enforce this. Reset clears the control state and sets the entry count to
// one; the table is not cleared and entries must be loaded before they are
// sampled.
module weighted_random_select (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wrs_pkg::CountBits-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [wrs_pkg::IdxBits-1:0]    entry_index_i,
  input  logic [wrs_pkg::WeightBits-1:0] cumul_weight_i,
  input  logic [wrs_pkg::RandBits-1:0]   random_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wrs_pkg::IdxBits-1:0]    selected_index_o
);
  import wrs_pkg::*;

  wrs_cmd_t cmd;
  wrs_sts_t sts;

  // Controller.
  wrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  wrs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .entry_index_i    (entry_index_i),
    .cumul_weight_i   (cumul_weight_i),
    .random_value_i   (random_value_i),
    .selected_index_o (selected_index_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

`ifndef NO_ASSERTIONS
  // A sample beat makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == ReqSample |=> !in_ready_o)
    else $error("sample beat did not start a search");

  // A load beat finishes in its accept cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == ReqLoad |=> in_ready_o)
    else $error("load beat left the block busy");

  // A new result only appears at the end of a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a search");

  // A stalled result holds its index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(selected_index_o))
    else $error("stalled result changed");
`endif

endmodule
